>>> design/stt_pkg.sv
`default_nettype none

package stt_pkg;

  // Table geometry
  localparam int MAX_STOPS = 32;
  localparam int CNT_W     = $clog2(MAX_STOPS + 1);

  // Field widths
  localparam int KIND_W   = 2;
  localparam int INPOS_W  = 16;
  localparam int POS_W    = 15;
  localparam int TYPE_W   = 3;
  localparam int LEAD_W   = 3;
  localparam int SLOT_W   = 5;
  localparam int STAT_W   = 3;
  localparam int OCOUNT_W = 6;

  typedef enum logic [KIND_W-1:0] {
    KIND_SET   = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_READ  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED   = 3'd0,
    ST_REPLACED   = 3'd1,
    ST_REMOVED    = 3'd2,
    ST_NOT_FOUND  = 3'd3,
    ST_IGNORED    = 3'd4,
    ST_FULL       = 3'd5,
    ST_READ_OK    = 3'd6,
    ST_READ_EMPTY = 3'd7
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;    // capture the incoming operation
    logic commit;  // update the table and the result register
  } cmd_t;

endpackage

`default_nettype wire

>>> design/stt_if.sv
`default_nettype none

interface stt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic signed [15:0] position;
  logic [2:0]  tab_type;
  logic [2:0]  tab_leader;
  logic [4:0]  slot;

  modport source (output valid, kind, position, tab_type, tab_leader, slot, input ready);
  modport sink   (input valid, kind, position, tab_type, tab_leader, slot, output ready);
endinterface

interface stt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [5:0]  stop_count;
  logic [14:0] read_position;
  logic [2:0]  read_type;
  logic [2:0]  read_leader;

  modport source (output valid, status, stop_count, read_position, read_type, read_leader,
                  input ready);
  modport sink   (input valid, status, stop_count, read_position, read_type, read_leader,
                  output ready);
endinterface

`default_nettype wire

>>> design/stt_ctrl.sv
`default_nettype none

module stt_ctrl (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  wire logic        out_ready,
  output stt_pkg::cmd_t    cmd
);
  import stt_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    in_ready      = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        // commit only once the result register is free
        if (!out_valid_r || out_ready) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_load_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == S_EXEC) && !in_ready)
    else $error("load did not move to execute");

  a_commit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("commit did not raise the result valid");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_ready))
    else $error("commit over an untaken result");

endmodule

`default_nettype wire

>>> design/stt_datapath.sv
`default_nettype none

module stt_datapath (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire stt_pkg::cmd_t                cmd,
  input  wire logic [stt_pkg::KIND_W-1:0]   in_kind,
  input  wire logic [stt_pkg::INPOS_W-1:0]  in_position,
  input  wire logic [stt_pkg::TYPE_W-1:0]   in_tab_type,
  input  wire logic [stt_pkg::LEAD_W-1:0]   in_tab_leader,
  input  wire logic [stt_pkg::SLOT_W-1:0]   in_slot,
  output logic [stt_pkg::STAT_W-1:0]        out_status,
  output logic [stt_pkg::OCOUNT_W-1:0]      out_stop_count,
  output logic [stt_pkg::POS_W-1:0]         out_read_position,
  output logic [stt_pkg::TYPE_W-1:0]        out_read_type,
  output logic [stt_pkg::LEAD_W-1:0]        out_read_leader
);
  import stt_pkg::*;

  // Captured operation
  kind_t                op_kind_r;
  logic [INPOS_W-1:0]   op_pos_r;
  logic [TYPE_W-1:0]    op_type_r;
  logic [LEAD_W-1:0]    op_lead_r;
  logic [SLOT_W-1:0]    op_slot_r;

  // Table cells
  logic [POS_W-1:0]  pos_r  [MAX_STOPS];
  logic [TYPE_W-1:0] typ_r  [MAX_STOPS];
  logic [LEAD_W-1:0] lead_r [MAX_STOPS];
  logic [POS_W-1:0]  pos_nxt  [MAX_STOPS];
  logic [TYPE_W-1:0] typ_nxt  [MAX_STOPS];
  logic [LEAD_W-1:0] lead_nxt [MAX_STOPS];
  logic [CNT_W-1:0]  count_r, count_nxt;

  // Result register
  status_t            res_status_r, res_status_nxt;
  logic [POS_W-1:0]   res_pos_r, res_pos_nxt;
  logic [TYPE_W-1:0]  res_type_r, res_type_nxt;
  logic [LEAD_W-1:0]  res_lead_r, res_lead_nxt;

  // Per-cell compare results
  logic [MAX_STOPS-1:0] valid_c, match_c, gt_c, lt_c;
  logic                 any_match, positive, is_full;
  logic [POS_W-1:0]     p15;

  // Capture the operation on input transfer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_kind_r <= kind_t'(in_kind);
      op_pos_r  <= in_position;
      op_type_r <= in_tab_type;
      op_lead_r <= in_tab_leader;
      op_slot_r <= in_slot;
    end
  end

  // Compare the operation position against every cell in parallel
  always_comb begin
    p15      = op_pos_r[POS_W-1:0];
    positive = !op_pos_r[INPOS_W-1] && (op_pos_r != '0);
    is_full  = (int'(count_r) >= MAX_STOPS);
    for (int i = 0; i < MAX_STOPS; i++) begin
      valid_c[i] = (i < int'(count_r));
      match_c[i] = valid_c[i] && (pos_r[i] == p15);
      gt_c[i]    = valid_c[i] && (pos_r[i] > p15);
      lt_c[i]    = valid_c[i] && (pos_r[i] < p15);
    end
    any_match = |match_c;
  end

  // Compute the table update and the result
  always_comb begin
    for (int i = 0; i < MAX_STOPS; i++) begin
      pos_nxt[i]  = pos_r[i];
      typ_nxt[i]  = typ_r[i];
      lead_nxt[i] = lead_r[i];
    end
    count_nxt      = count_r;
    res_status_nxt = ST_IGNORED;
    res_pos_nxt    = '0;
    res_type_nxt   = '0;
    res_lead_nxt   = '0;

    case (op_kind_r)
      KIND_SET: begin
        if (!positive) begin
          res_status_nxt = ST_IGNORED;
        end else if (any_match) begin
          // same position keeps its place: overwrite type and leader
          for (int i = 0; i < MAX_STOPS; i++) begin
            if (match_c[i]) begin
              typ_nxt[i]  = op_type_r;
              lead_nxt[i] = op_lead_r;
            end
          end
          res_status_nxt = ST_REPLACED;
        end else if (is_full) begin
          res_status_nxt = ST_FULL;
        end else begin
          // shift larger stops up one cell and drop the new stop into the gap
          for (int i = 0; i < MAX_STOPS; i++) begin
            if (i > 0 && gt_c[i-1]) begin
              pos_nxt[i]  = pos_r[i-1];
              typ_nxt[i]  = typ_r[i-1];
              lead_nxt[i] = lead_r[i-1];
            end else if ((i == 0 || lt_c[i-1]) && !lt_c[i]) begin
              pos_nxt[i]  = p15;
              typ_nxt[i]  = op_type_r;
              lead_nxt[i] = op_lead_r;
            end
          end
          count_nxt      = count_r + CNT_W'(1);
          res_status_nxt = ST_INSERTED;
        end
      end
      KIND_CLEAR: begin
        if (positive && any_match) begin
          // cells at or above the match pull from the next cell; top gets zero
          for (int i = 0; i < MAX_STOPS; i++) begin
            if (!valid_c[i] || pos_r[i] >= p15) begin
              if (i + 1 < MAX_STOPS) begin
                pos_nxt[i]  = pos_r[i+1];
                typ_nxt[i]  = typ_r[i+1];
                lead_nxt[i] = lead_r[i+1];
              end else begin
                pos_nxt[i]  = '0;
                typ_nxt[i]  = '0;
                lead_nxt[i] = '0;
              end
            end
          end
          count_nxt      = count_r - CNT_W'(1);
          res_status_nxt = ST_REMOVED;
        end else begin
          res_status_nxt = ST_NOT_FOUND;
        end
      end
      KIND_READ: begin
        res_status_nxt = ST_READ_EMPTY;
        for (int i = 0; i < MAX_STOPS; i++) begin
          if (valid_c[i] && (int'(op_slot_r) == i)) begin
            res_status_nxt = ST_READ_OK;
            res_pos_nxt    = pos_r[i];
            res_type_nxt   = typ_r[i];
            res_lead_nxt   = lead_r[i];
          end
        end
      end
      default: begin
        res_status_nxt = ST_IGNORED;
      end
    endcase
  end

  // Hold the table and the count; clear them on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      for (int i = 0; i < MAX_STOPS; i++) begin
        pos_r[i]  <= '0;
        typ_r[i]  <= '0;
        lead_r[i] <= '0;
      end
    end else if (cmd.commit) begin
      count_r <= count_nxt;
      for (int i = 0; i < MAX_STOPS; i++) begin
        pos_r[i]  <= pos_nxt[i];
        typ_r[i]  <= typ_nxt[i];
        lead_r[i] <= lead_nxt[i];
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_status_r <= res_status_nxt;
      res_pos_r    <= res_pos_nxt;
      res_type_r   <= res_type_nxt;
      res_lead_r   <= res_lead_nxt;
    end
  end

  assign out_status        = res_status_r;
  assign out_stop_count    = OCOUNT_W'(count_r);
  assign out_read_position = res_pos_r;
  assign out_read_type     = res_type_r;
  assign out_read_leader   = res_lead_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) <= MAX_STOPS)
    else $error("stop count beyond table size");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && res_status_nxt == ST_INSERTED) |=>
      count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not grow the count");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && res_status_nxt == ST_REMOVED) |=>
      count_r == $past(count_r) - CNT_W'(1))
    else $error("remove did not shrink the count");

  a_match_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match_c))
    else $error("position held in more than one cell");

endmodule

`default_nettype wire

>>> design/sorted_tab_stop_table_top.sv
// Each operation is captured on its input transfer, then executes: all 32 cells compare and
// shift in parallel, and the commit loads the table and the result register and raises the
// result valid. A stalled result holds execute; no new operation is taken during execute.
// The next operation is taken while an earlier result still waits.
// Reset (synchronous, rst_n low) empties the table and zeroes every cell at once.
`default_nettype none

module sorted_tab_stop_table_top (
  input  wire logic clk,
  input  wire logic rst_n,
  stt_in_if.sink    in_chan,
  stt_out_if.source out_chan
);
  import stt_pkg::*;

  cmd_t cmd;

  stt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd)
  );

  stt_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_kind           (in_chan.kind),
    .in_position       (in_chan.position),
    .in_tab_type       (in_chan.tab_type),
    .in_tab_leader     (in_chan.tab_leader),
    .in_slot           (in_chan.slot),
    .out_status        (out_chan.status),
    .out_stop_count    (out_chan.stop_count),
    .out_read_position (out_chan.read_position),
    .out_read_type     (out_chan.read_type),
    .out_read_leader   (out_chan.read_leader)
  );

endmodule

`default_nettype wire

>>> test/tb_top.sv
module tb_top;
  import stt_pkg::*;

  localparam int QUIET_LIMIT     = 4000;
  localparam int HOLD_CYCLES     = 300;
  localparam int ITEMS_PER_PHASE = 385;
  localparam int POOL_SIZE       = 40;

  typedef struct packed {
    kind_t              kind;
    logic signed [15:0] pos;
    logic [2:0]         ttype;
    logic [2:0]         lead;
    logic [4:0]         slot;
  } tab_edit_t;

  typedef struct packed {
    status_t     status;
    logic [5:0]  count;
    logic [14:0] rpos;
    logic [2:0]  rtype;
    logic [2:0]  rlead;
  } tab_res_t;

  typedef struct packed {
    tab_edit_t edit;
    bit        by_hand;
    tab_res_t  res;
  } edit_row_t;

  localparam tab_res_t NO_RES = '{ST_IGNORED, 6'd0, 15'd0, 3'd0, 3'd0};

  // Hand-checked rows carry their result; the rest go through the table model
  edit_row_t directed_rows [0:22] = '{
    '{'{KIND_READ,  16'sh0000, 3'd0, 3'd0, 5'd0},  1'b1, '{ST_READ_EMPTY, 6'd0, 15'd0, 3'd0, 3'd0}},
    '{'{KIND_READ,  16'sh0000, 3'd7, 3'd7, 5'd31}, 1'b1, '{ST_READ_EMPTY, 6'd0, 15'd0, 3'd0, 3'd0}},
    '{'{KIND_SET,   16'sh0000, 3'd5, 3'd5, 5'd0},  1'b1, '{ST_IGNORED, 6'd0, 15'd0, 3'd0, 3'd0}},
    '{'{KIND_SET,   16'shFFFF, 3'd7, 3'd7, 5'd31}, 1'b1, '{ST_IGNORED, 6'd0, 15'd0, 3'd0, 3'd0}},
    '{'{KIND_SET,   16'sh8000, 3'd1, 3'd2, 5'd0},  1'b1, '{ST_IGNORED, 6'd0, 15'd0, 3'd0, 3'd0}},
    '{'{KIND_CLEAR, 16'sd100,  3'd0, 3'd0, 5'd0},  1'b1, '{ST_NOT_FOUND, 6'd0, 15'd0, 3'd0, 3'd0}},
    '{'{KIND_NONE,  16'sh7FFF, 3'd7, 3'd7, 5'd31}, 1'b1, '{ST_IGNORED, 6'd0, 15'd0, 3'd0, 3'd0}},
    '{'{KIND_SET,   16'sh7FFF, 3'd7, 3'd7, 5'd0},  1'b1, '{ST_INSERTED, 6'd1, 15'd0, 3'd0, 3'd0}},
    '{'{KIND_SET,   16'sh0001, 3'd0, 3'd0, 5'd0},  1'b1, '{ST_INSERTED, 6'd2, 15'd0, 3'd0, 3'd0}},
    '{'{KIND_SET,   16'sd500,  3'd3, 3'd5, 5'd0},  1'b1, '{ST_INSERTED, 6'd3, 15'd0, 3'd0, 3'd0}},
    '{'{KIND_READ,  16'sh0000, 3'd0, 3'd0, 5'd0},  1'b1, '{ST_READ_OK, 6'd3, 15'd1, 3'd0, 3'd0}},
    '{'{KIND_READ,  16'sh0000, 3'd0, 3'd0, 5'd2},  1'b1,
      '{ST_READ_OK, 6'd3, 15'h7FFF, 3'd7, 3'd7}},
    '{'{KIND_READ,  16'sh0000, 3'd0, 3'd0, 5'd3},  1'b1, '{ST_READ_EMPTY, 6'd3, 15'd0, 3'd0, 3'd0}},
    '{'{KIND_SET,   16'sd500,  3'd6, 3'd1, 5'd0},  1'b1, '{ST_REPLACED, 6'd3, 15'd0, 3'd0, 3'd0}},
    '{'{KIND_READ,  16'sh0000, 3'd0, 3'd0, 5'd1},  1'b0, NO_RES},
    '{'{KIND_CLEAR, 16'shFFFF, 3'd0, 3'd0, 5'd0},  1'b1, '{ST_NOT_FOUND, 6'd3, 15'd0, 3'd0, 3'd0}},
    '{'{KIND_CLEAR, 16'sh0000, 3'd0, 3'd0, 5'd0},  1'b1, '{ST_NOT_FOUND, 6'd3, 15'd0, 3'd0, 3'd0}},
    '{'{KIND_CLEAR, 16'sh0001, 3'd0, 3'd0, 5'd0},  1'b1, '{ST_REMOVED, 6'd2, 15'd0, 3'd0, 3'd0}},
    '{'{KIND_READ,  16'sh0000, 3'd0, 3'd0, 5'd0},  1'b0, NO_RES},
    '{'{KIND_SET,   16'sh4000, 3'd2, 3'd4, 5'd0},  1'b0, NO_RES},
    '{'{KIND_CLEAR, 16'sh7FFF, 3'd0, 3'd0, 5'd0},  1'b0, NO_RES},
    '{'{KIND_READ,  16'sh0000, 3'd0, 3'd0, 5'd2},  1'b0, NO_RES},
    '{'{KIND_NONE,  16'sh0000, 3'd0, 3'd0, 5'd0},  1'b1, '{ST_IGNORED, 6'd2, 15'd0, 3'd0, 3'd0}}
  };

  int send_idle_tab [4] = '{0, 74, 0, 31};
  int recv_stall_tab [4] = '{0, 0, 74, 31};

  logic clk = 1'b0;
  logic rst_n;

  stt_in_if  in_chan ();
  stt_out_if out_chan ();

  sorted_tab_stop_table_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  // Shadow copy of the stop table
  logic [14:0] held_pos [MAX_STOPS];
  logic [2:0]  held_type [MAX_STOPS];
  logic [2:0]  held_lead [MAX_STOPS];
  int          held_count;

  logic [14:0] pos_pool [POOL_SIZE];
  tab_res_t    results_due [$];
  int          bad_results = 0;
  int          quiet_cycles = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  bit          hold_req = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Remove the stop at a position, close the gap and zero the freed slot
  function automatic bit drop_stop_at(logic [14:0] p);
    for (int i = 0; i < held_count; i++) begin
      if (held_pos[i] == p) begin
        for (int j = i; j + 1 < held_count; j++) begin
          held_pos[j]  = held_pos[j+1];
          held_type[j] = held_type[j+1];
          held_lead[j] = held_lead[j+1];
        end
        held_count--;
        held_pos[held_count]  = '0;
        held_type[held_count] = '0;
        held_lead[held_count] = '0;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Apply one edit to the shadow table and return the result it produces
  function automatic tab_res_t apply_tab_edit(tab_edit_t e);
    tab_res_t r;
    bit       had;
    int       at;
    r = NO_RES;
    case (e.kind)
      KIND_SET: begin
        if ($signed(e.pos) <= 0) begin
          r.status = ST_IGNORED;
        end else begin
          had = drop_stop_at(e.pos[14:0]);
          if (held_count >= MAX_STOPS) begin
            r.status = ST_FULL;
          end else begin
            at = held_count;
            while (at > 0 && held_pos[at-1] > e.pos[14:0]) begin
              held_pos[at]  = held_pos[at-1];
              held_type[at] = held_type[at-1];
              held_lead[at] = held_lead[at-1];
              at--;
            end
            held_pos[at]  = e.pos[14:0];
            held_type[at] = e.ttype;
            held_lead[at] = e.lead;
            held_count++;
            if (had) r.status = ST_REPLACED;
            else r.status = ST_INSERTED;
          end
        end
      end
      KIND_CLEAR: begin
        if ($signed(e.pos) > 0 && drop_stop_at(e.pos[14:0])) r.status = ST_REMOVED;
        else r.status = ST_NOT_FOUND;
      end
      KIND_READ: begin
        if (e.slot < held_count) begin
          r.status = ST_READ_OK;
          r.rpos   = held_pos[e.slot];
          r.rtype  = held_type[e.slot];
          r.rlead  = held_lead[e.slot];
        end else begin
          r.status = ST_READ_EMPTY;
        end
      end
      default: r.status = ST_IGNORED;
    endcase
    r.count = held_count[5:0];
    return r;
  endfunction

  // Offer one edit, hold it until the transfer, then queue its result
  task automatic send_edit(input tab_edit_t e, input bit by_hand, input tab_res_t hand_res);
    tab_res_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.kind       <= e.kind;
    in_chan.position   <= e.pos;
    in_chan.tab_type   <= e.ttype;
    in_chan.tab_leader <= e.lead;
    in_chan.slot       <= e.slot;
    @(posedge clk);
    while (in_chan.ready !== 1'b1) @(posedge clk);
    predicted = apply_tab_edit(e);
    results_due.push_back(by_hand ? hand_res : predicted);
  endtask

  // Stop offering and wait until every queued result has come back
  task automatic wait_results_drained();
    in_chan.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Result side: random stalls, plus a long hold-off on request
  initial begin : result_taker
    int hold_left;
    hold_left = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Compare each result transfer against the oldest queued result
  always @(posedge clk) begin : check_results
    tab_res_t got;
    tab_res_t want;
    if (rst_n === 1'b1 && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      got = '{status_t'(out_chan.status), out_chan.stop_count, out_chan.read_position,
              out_chan.read_type, out_chan.read_leader};
      if (results_due.size() == 0) begin
        if (bad_results < 10)
          $display("unexpected result: status=%0d count=%0d pos=%0d type=%0d lead=%0d",
                   got.status, got.count, got.rpos, got.rtype, got.rlead);
        bad_results++;
      end else begin
        want = results_due.pop_front();
        if (got !== want) begin
          if (bad_results < 10)
            $display({"mismatch: expected status=%0d count=%0d pos=%0d type=%0d lead=%0d,",
                      " got status=%0d count=%0d pos=%0d type=%0d lead=%0d"},
                     want.status, want.count, want.rpos, want.rtype, want.rlead,
                     got.status, got.count, got.rpos, got.rtype, got.rlead);
          bad_results++;
        end
      end
    end
  end

  // Watchdog: end the run if nothing transfers for too long
  always @(posedge clk) begin
    if ((in_chan.valid === 1'b1 && in_chan.ready === 1'b1) ||
        (out_chan.valid === 1'b1 && out_chan.ready === 1'b1))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    tab_edit_t e;
    int        pick;
    bit        filling;

    // Drive every input to a known value and hold reset
    in_chan.valid      <= 1'b0;
    in_chan.kind       <= KIND_NONE;
    in_chan.position   <= '0;
    in_chan.tab_type   <= '0;
    in_chan.tab_leader <= '0;
    in_chan.slot       <= '0;
    rst_n              <= 1'b0;
    for (int i = 0; i < MAX_STOPS; i++) begin
      held_pos[i]  = '0;
      held_type[i] = '0;
      held_lead[i] = '0;
    end
    held_count = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    foreach (directed_rows[i])
      send_edit(directed_rows[i].edit, directed_rows[i].by_hand, directed_rows[i].res);
    wait_results_drained();

    // Random phases: fill toward a full table, then drain, and repeat
    filling = 1'b1;
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = send_idle_tab[ph];
      stall_pct     = recv_stall_tab[ph];
      foreach (pos_pool[i]) pos_pool[i] = 15'($urandom_range(32767, 1));
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 0 && n == 100) hold_req = 1'b1;
        if (held_count == MAX_STOPS) filling = 1'b0;
        else if (held_count < 4) filling = 1'b1;

        pick = $urandom_range(99);
        if (pick < (filling ? 60 : 15)) e.kind = KIND_SET;
        else if (pick < (filling ? 70 : 60)) e.kind = KIND_CLEAR;
        else if (pick < 94) e.kind = KIND_READ;
        else e.kind = KIND_NONE;

        // Mostly positions from a small pool so sets collide and clears hit
        pick = $urandom_range(99);
        if (e.kind == KIND_CLEAR && held_count > 0 && pick < 40)
          e.pos = {1'b0, held_pos[$urandom_range(held_count - 1)]};
        else if (pick < 80)
          e.pos = {1'b0, pos_pool[$urandom_range(POOL_SIZE - 1)]};
        else if (pick < 92)
          e.pos = 16'($urandom);
        else
          case ($urandom_range(4))
            0:       e.pos = 16'sh0000;
            1:       e.pos = 16'sh0001;
            2:       e.pos = 16'sh7FFF;
            3:       e.pos = 16'shFFFF;
            default: e.pos = 16'sh8000;
          endcase

        e.ttype = 3'($urandom);
        e.lead  = 3'($urandom);
        if (held_count > 0 && $urandom_range(1) == 1)
          e.slot = 5'($urandom_range(held_count - 1));
        else
          e.slot = 5'($urandom);
        send_edit(e, 1'b0, NO_RES);
      end
      wait_results_drained();
    end

    repeat (8) @(posedge clk);
    if (bad_results == 0 && results_due.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

>>> sorted_tab_stop_table_top.f
design/stt_pkg.sv
design/stt_if.sv
design/stt_ctrl.sv
design/stt_datapath.sv
design/sorted_tab_stop_table_top.sv
test/tb_top.sv
